// File: rtl/core/sxl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types, constants and helpers of the strided-to-XOR layout core.
// ----------------------------------------------------------------------------
package sxl_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_DIMS_DEF = 3;
  localparam int DIV_STEPS    = 64;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  localparam logic [2:0] REG_RANK        = 3'd0;
  localparam logic [2:0] REG_STRIDE_ZERO = 3'd1;
  localparam logic [2:0] REG_STRIDE_ONE  = 3'd2;
  localparam logic [2:0] REG_STRIDE_TWO  = 3'd3;
  localparam logic [2:0] REG_EXTENT_ZERO = 3'd4;
  localparam logic [2:0] REG_EXTENT_ONE  = 3'd5;
  localparam logic [2:0] REG_EXTENT_TWO  = 3'd6;
  localparam logic [2:0] REG_ROW_COUNT   = 3'd7;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  row_index;
    logic [63:0] row_mask;
    logic [63:0] element_offset;
  } in_req_t;

  typedef struct packed {
    logic [31:0] physical_offset;
    logic        envelope_error;
  } out_rsp_t;

  typedef struct packed {
    logic [31:0] divisor;
    logic [6:0]  shift;
    logic        active;
  } slot_cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  idx;
    logic [63:0] mask;
    logic [63:0] num;
    logic [63:0] orig;
    logic [31:0] rem;
    logic [63:0] logical;
  } pipe_t;

  function automatic logic [5:0] bit_count(input logic [31:0] extent);
    logic [31:0] v;
    logic [5:0]  b;
    v = extent - 32'd1;
    b = 6'd0;
    if (extent > 32'd1) begin
      for (int i = 0; i < 32; i++) begin
        if (v[i]) b = 6'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

// File: rtl/core/strided_to_xor_linear_layout_offset_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_to_xor_linear_layout_offset_core
// Maps element offsets through a strided layout and a GF(2) row matrix.
//
// Input channel in_*: one request per accepted item. cmd write stores a row
// mask, cmd map sends an element offset to be mapped; only maps produce a
// response on out_*. Both channels are valid/ready.
// Layout registers sit behind the APB-style cfg_* port; the user must write them only
// while the core is idle, and the core itself does not enforce this.
// Each request passes one restoring divider stage per quotient bit for each
// of the ordered dimensions, then the parity and output register.
// Throughput: one request per cycle while the receiver does not stall.
// Row masks take effect in request order: a write updates the store when it
// leaves the divider pipeline, so earlier maps still see the old mask.
// Reset clears the pipeline valid bits and loads every layout register with 1; row
// masks hold no reset value and must be written before use.
// A stalled receiver freezes the whole pipeline and drops in_ready.
// ----------------------------------------------------------------------------
module strided_to_xor_linear_layout_offset_core import sxl_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_rsp,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  slot_cfg_t [MAX_DIMS-1:0] slot_cfg;
  logic                     env_err;
  logic [5:0]               row_count;
  logic                     en;
  logic                     vld  [MAX_DIMS+1];
  pipe_t                    pipe [MAX_DIMS+1];

  sxl_cfg #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .slot_cfg    (slot_cfg),
    .env_err     (env_err),
    .row_count   (row_count)
  );

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign vld[0]          = in_valid;
  assign pipe[0].cmd     = in_req.cmd;
  assign pipe[0].idx     = in_req.row_index;
  assign pipe[0].mask    = in_req.row_mask;
  assign pipe[0].num     = in_req.element_offset;
  assign pipe[0].orig    = in_req.element_offset;
  assign pipe[0].rem     = 32'd0;
  assign pipe[0].logical = 64'd0;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_slot
    sxl_div_slot u_slot (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .cfg     (slot_cfg[k]),
      .valid_i (vld[k]),
      .pipe_i  (pipe[k]),
      .valid_o (vld[k+1]),
      .pipe_o  (pipe[k+1])
    );
  end

  sxl_parity #(.MAX_ROWS(MAX_ROWS)) u_parity (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_i   (vld[MAX_DIMS]),
    .pipe_i    (pipe[MAX_DIMS]),
    .env_err   (env_err),
    .row_count (row_count),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid) else $error("pipeline stalled without a held response");

  a_write_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld[MAX_DIMS] && pipe[MAX_DIMS].cmd == CMD_WRITE) |=> !out_valid)
    else $error("row mask write produced a response");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.envelope_error) |-> out_rsp.physical_offset == 32'd0)
    else $error("envelope error with non-zero offset");

  a_map_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld[MAX_DIMS] && pipe[MAX_DIMS].cmd == CMD_MAP) |=> out_valid)
    else $error("mapped request lost at output");

endmodule

// File: rtl/core/sxl_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_cfg
// Register file and registered layout decode: dimension order, shifts, error.
// ----------------------------------------------------------------------------
module sxl_cfg import sxl_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_DIMS = MAX_DIMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [4:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output slot_cfg_t [MAX_DIMS-1:0]   slot_cfg,
  output logic                       env_err,
  output logic [5:0]                 row_count
);

  logic [1:0]  rank_r;
  logic [31:0] stride_r [3];
  logic [31:0] extent_r [3];
  logic [5:0]  row_count_r;
  logic [2:0]  reg_idx;
  logic        wr;

  slot_cfg_t [MAX_DIMS-1:0] slot_r, slot_nxt;
  logic                     err_r, err_nxt;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r      <= 2'd1;
      stride_r    <= '{32'd1, 32'd1, 32'd1};
      extent_r    <= '{32'd1, 32'd1, 32'd1};
      row_count_r <= 6'd1;
    end else if (wr) begin
      unique case (reg_idx)
        REG_RANK:        rank_r      <= cfg_pwdata[1:0];
        REG_STRIDE_ZERO: stride_r[0] <= cfg_pwdata;
        REG_STRIDE_ONE:  stride_r[1] <= cfg_pwdata;
        REG_STRIDE_TWO:  stride_r[2] <= cfg_pwdata;
        REG_EXTENT_ZERO: extent_r[0] <= cfg_pwdata;
        REG_EXTENT_ONE:  extent_r[1] <= cfg_pwdata;
        REG_EXTENT_TWO:  extent_r[2] <= cfg_pwdata;
        REG_ROW_COUNT:   row_count_r <= cfg_pwdata[5:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RANK:        cfg_prdata = {30'd0, rank_r};
      REG_STRIDE_ZERO: cfg_prdata = stride_r[0];
      REG_STRIDE_ONE:  cfg_prdata = stride_r[1];
      REG_STRIDE_TWO:  cfg_prdata = stride_r[2];
      REG_EXTENT_ZERO: cfg_prdata = extent_r[0];
      REG_EXTENT_ONE:  cfg_prdata = extent_r[1];
      REG_EXTENT_TWO:  cfg_prdata = extent_r[2];
      REG_ROW_COUNT:   cfg_prdata = {26'd0, row_count_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [1:0] n;
    logic [6:0] acc;
    logic [6:0] shf [3];
    logic [1:0] pos [3];
    n   = rank_r;
    acc = 7'd0;
    if (rank_r == 2'd0) n = 2'd1;
    else if (int'(rank_r) > MAX_DIMS) n = 2'(MAX_DIMS);
    for (int d = 0; d < 3; d++) begin
      shf[d] = acc;
      pos[d] = 2'd0;
      if (d < MAX_DIMS && d < int'(n)) acc = acc + 7'(bit_count(extent_r[d]));
    end
    for (int d = 0; d < 3; d++) begin
      for (int j = 0; j < 3; j++) begin
        if (j < int'(n) && (stride_r[j] > stride_r[d] ||
            (stride_r[j] == stride_r[d] && j < d))) begin
          pos[d] = pos[d] + 2'd1;
        end
      end
    end
    err_nxt = (row_count_r == 6'd0) || (int'(row_count_r) > MAX_ROWS) ||
              (acc != 7'(row_count_r));
    for (int k = 0; k < MAX_DIMS; k++) begin
      slot_nxt[k] = '0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (d < int'(n) && int'(pos[d]) == k) begin
          slot_nxt[k].divisor = stride_r[d];
          slot_nxt[k].shift   = shf[d];
          slot_nxt[k].active  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      err_r  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      err_r  <= err_nxt;
    end
  end

  assign slot_cfg  = slot_r;
  assign env_err   = err_r;
  assign row_count = row_count_r;

endmodule

// File: rtl/core/sxl_div_slot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_div_slot
// One ordered dimension: 64-stage restoring divider, one quotient bit per
// stage, then the coordinate is merged into the logical word.
// ----------------------------------------------------------------------------
module sxl_div_slot import sxl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  slot_cfg_t cfg,
  input  logic      valid_i,
  input  pipe_t     pipe_i,
  output logic      valid_o,
  output pipe_t     pipe_o
);

  logic  vld_r   [DIV_STEPS];
  pipe_t stage_r [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    pipe_t       cur, stage_nxt;
    logic        vld_in;
    logic [32:0] r, rs;
    logic        ge;
    logic [63:0] rem64;

    if (s == 0) begin : g_first
      assign cur    = pipe_i;
      assign vld_in = valid_i;
    end else begin : g_mid
      assign cur    = stage_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    assign r     = {cur.rem, cur.num[63]};
    assign ge    = r >= {1'b0, cfg.divisor};
    assign rs    = ge ? r - {1'b0, cfg.divisor} : r;
    assign rem64 = {32'd0, rs[31:0]};

    always_comb begin
      stage_nxt     = cur;
      stage_nxt.num = {cur.num[62:0], ge};
      stage_nxt.rem = rs[31:0];
      if (s == DIV_STEPS - 1) begin
        if (cfg.active && cfg.shift < 7'd64) begin
          stage_nxt.logical = cur.logical | ({cur.num[62:0], ge} << cfg.shift[5:0]);
        end
        stage_nxt.num  = (cfg.divisor == 32'd0) ? cur.orig : rem64;
        stage_nxt.orig = stage_nxt.num;
        stage_nxt.rem  = 32'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else if (en) vld_r[s] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) stage_r[s] <= stage_nxt;
    end
  end

  assign valid_o = vld_r[DIV_STEPS-1];
  assign pipe_o  = stage_r[DIV_STEPS-1];

endmodule

// File: rtl/core/sxl_parity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxl_parity
// Row mask store, row parity and the output register.
// ----------------------------------------------------------------------------
module sxl_parity import sxl_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     valid_i,
  input  pipe_t    pipe_i,
  input  logic     env_err,
  input  logic [5:0] row_count,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NPHYS = (MAX_ROWS < 32) ? MAX_ROWS : 32;

  logic [63:0]      row_masks [MAX_ROWS];
  logic [ROW_W-1:0] widx;
  logic [31:0]      phys;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r, out_rsp_nxt;

  assign widx = ROW_W'(pipe_i.idx);

  always_ff @(posedge clk) begin
    if (en && valid_i && pipe_i.cmd == CMD_WRITE && int'(pipe_i.idx) < MAX_ROWS) begin
      row_masks[widx] <= pipe_i.mask;
    end
  end

  always_comb begin
    phys = 32'd0;
    for (int k = 0; k < NPHYS; k++) begin
      if (k < int'(row_count)) phys[k] = ^(pipe_i.logical & row_masks[k]);
    end
    out_rsp_nxt.physical_offset = env_err ? 32'd0 : phys;
    out_rsp_nxt.envelope_error  = env_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= valid_i && pipe_i.cmd == CMD_MAP;
  end

  always_ff @(posedge clk) begin
    if (en) out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the strided-to-XOR layout core: row-mask writes and
// offset maps are pushed through the valid/ready request channel under random
// gaps and receiver stalls. Each map is predicted from the layout registers
// and the row masks, and the responses are compared in order.
// ----------------------------------------------------------------------------
module tb;
  import sxl_pkg::*;

  localparam int LATENCY = 64 * MAX_DIMS_DEF + 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_rsp_t    out_rsp;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  strided_to_xor_linear_layout_offset_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // layout shadow
  logic [1:0]  lay_rank;
  logic [31:0] lay_stride [3];
  logic [31:0] lay_extent [3];
  logic [5:0]  lay_rows;
  logic [63:0] mask_store [32];

  out_rsp_t    pending_maps [$];
  int          errors = 0;
  int          maps_sent = 0;
  int          writes_sent = 0;
  int          checked = 0;
  bit          long_hold = 1'b0;

  function automatic int extent_bits(logic [31:0] e);
    int b;
    longint unsigned cap;
    b = 0;
    cap = 1;
    while (cap < longint'(e)) begin
      cap = cap << 1;
      b++;
    end
    return b;
  endfunction

  function automatic out_rsp_t swizzle_offset(logic [63:0] off);
    out_rsp_t r;
    int n, total, k, j, t;
    int sh [3];
    int ord [3];
    logic [63:0] rem, logical, coord, acc;
    n = (lay_rank == 0) ? 1 : ((lay_rank > MAX_DIMS_DEF) ? MAX_DIMS_DEF : lay_rank);
    total = 0;
    for (k = 0; k < n; k++) begin
      sh[k] = total;
      total += extent_bits(lay_extent[k]);
    end
    r = '0;
    if (lay_rows == 0 || lay_rows > MAX_ROWS_DEF || total != lay_rows) begin
      r.envelope_error = 1'b1;
      return r;
    end
    for (k = 0; k < n; k++) ord[k] = k;
    for (k = 1; k < n; k++)
      for (j = k; j > 0 && lay_stride[ord[j-1]] < lay_stride[ord[j]]; j--) begin
        t = ord[j]; ord[j] = ord[j-1]; ord[j-1] = t;
      end
    rem = off;
    logical = '0;
    for (k = 0; k < n; k++) begin
      if (lay_stride[ord[k]] == 0) coord = '1;
      else begin
        coord = rem / lay_stride[ord[k]];
        rem = rem % lay_stride[ord[k]];
      end
      if (sh[ord[k]] < 64) logical |= coord << sh[ord[k]];
    end
    for (k = 0; k < lay_rows && k < 32; k++) begin
      acc = logical & mask_store[k];
      r.physical_offset[k] = ^acc;
    end
    return r;
  endfunction

  task automatic cfg_write(logic [2:0] reg_idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {reg_idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (reg_idx)
      REG_RANK:        lay_rank = val[1:0];
      REG_STRIDE_ZERO: lay_stride[0] = val;
      REG_STRIDE_ONE:  lay_stride[1] = val;
      REG_STRIDE_TWO:  lay_stride[2] = val;
      REG_EXTENT_ZERO: lay_extent[0] = val;
      REG_EXTENT_ONE:  lay_extent[1] = val;
      REG_EXTENT_TWO:  lay_extent[2] = val;
      REG_ROW_COUNT:   lay_rows = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(logic [1:0] rk, logic [31:0] s0, s1, s2,
                            logic [31:0] e0, e1, e2, logic [5:0] rows);
    cfg_write(REG_RANK, {30'd0, rk});
    cfg_write(REG_STRIDE_ZERO, s0);
    cfg_write(REG_STRIDE_ONE, s1);
    cfg_write(REG_STRIDE_TWO, s2);
    cfg_write(REG_EXTENT_ZERO, e0);
    cfg_write(REG_EXTENT_ONE, e1);
    cfg_write(REG_EXTENT_TWO, e2);
    cfg_write(REG_ROW_COUNT, {26'd0, rows});
  endtask

  task automatic gap(int chance_long);
    int g;
    if ($urandom_range(99) < chance_long) g = $urandom_range(40, 8);
    else if ($urandom_range(2) == 0) g = $urandom_range(2, 1);
    else g = 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // one request; prediction is made at acceptance, in request order
  task automatic send_req(in_req_t r, bit use_gap, bit has_exp, out_rsp_t exp);
    if (use_gap) gap(3);
    in_req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.cmd == CMD_WRITE) begin
      mask_store[r.row_index] = r.row_mask;
      writes_sent++;
    end else begin
      if (has_exp) pending_maps = {pending_maps, exp};
      else pending_maps = {pending_maps, swizzle_offset(r.element_offset)};
      maps_sent++;
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_req_t mk_write(int idx, logic [63:0] m);
    in_req_t r;
    r = '0;
    r.cmd = CMD_WRITE; r.row_index = idx[4:0]; r.row_mask = m;
    r.element_offset = rand64();
    return r;
  endfunction

  function automatic in_req_t mk_map(logic [63:0] off);
    in_req_t r;
    r.cmd = CMD_MAP; r.row_index = 5'($urandom()); r.row_mask = rand64();
    r.element_offset = off;
    return r;
  endfunction

  task automatic fill_masks();
    for (int i = 0; i < 32; i++) send_req(mk_write(i, rand64()), 1'b1, 1'b0, '0);
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else if ($urandom_range(99) < 4) out_ready <= 1'b0;
    else if ($urandom_range(99) < 25) out_ready <= ~out_ready;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_maps.size() == 0) begin
        $error("response with no map outstanding");
        errors++;
      end else begin
        e = pending_maps.pop_front();
        checked++;
        if (out_rsp.physical_offset !== e.physical_offset) begin
          $error("physical_offset: expected %h, got %h", e.physical_offset,
                 out_rsp.physical_offset);
          errors++;
        end
        if (out_rsp.envelope_error !== e.envelope_error) begin
          $error("envelope_error: expected %b, got %b", e.envelope_error,
                 out_rsp.envelope_error);
          errors++;
        end
      end
    end
  end

  typedef struct {
    in_req_t  r;
    bit       has_exp;
    out_rsp_t exp;
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    dir_row_t d;
    int hold;
    lay_rank = 1; lay_rows = 1;
    for (int i = 0; i < 3; i++) begin lay_stride[i] = 1; lay_extent[i] = 1; end
    for (int i = 0; i < 32; i++) mask_store[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset: rank 1, extent 1 -> 0 bits != 1 row -> envelope error
    d.r = mk_map('1); d.has_exp = 1; d.exp = '{physical_offset: 0, envelope_error: 1};
    rows = {rows, d};
    d.r = mk_map('0); rows = {rows, d};
    foreach (rows[i]) send_req(rows[i].r, 1'b0, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain();

    // full 32-row layout, extremes of the offset and masks
    set_layout(2'd1, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'd1, 6'd32);
    for (int i = 0; i < 32; i++)
      send_req(mk_write(i, (i % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1 << i), 1'b0, 0, '0);
    d.has_exp = 0;
    d.r = mk_map(64'd0); rows = {rows, d};
    d.r = mk_map('1); rows = {rows, d};
    d.r = mk_map(64'h8000_0000_0000_0000); rows = {rows, d};
    d.r = mk_map(64'd1); rows = {rows, d};
    d.r = mk_map(64'h0000_0000_A5A5_5A5A); rows = {rows, d};
    foreach (rows[i]) send_req(rows[i].r, 1'b0, rows[i].has_exp, rows[i].exp);
    rows.delete();
    drain();

    // stride zero, tie ordering, extent zero, rank 0 and 3, row count over max
    set_layout(2'd3, 32'd0, 32'd4, 32'd4, 32'd0, 32'd16, 32'd16, 6'd8);
    send_req(mk_map(64'd77), 1'b0, 0, '0);
    send_req(mk_map('1), 1'b0, 0, '0);
    drain();
    set_layout(2'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd256, 32'd1, 32'd1, 6'd8);
    send_req(mk_map('1), 1'b0, 0, '0);
    send_req(mk_map(64'h1234_5678_9ABC_DEF0), 1'b0, 0, '0);
    drain();
    set_layout(2'd2, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 6'd0);
    d.r = mk_map(64'd5); d.has_exp = 1; d.exp = '{physical_offset: 0, envelope_error: 1};
    send_req(d.r, 1'b0, 1, d.exp);
    drain();
    set_layout(2'd2, 32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 6'd63);
    send_req(d.r, 1'b0, 1, d.exp);
    drain();

    // random phases: consistent layouts mostly, broken ones sometimes
    for (int ph = 0; ph < 12; ph++) begin
      int rk, b0, b1, b2, tot;
      logic [31:0] e [3];
      logic [31:0] s [3];
      rk = $urandom_range(3, 1);
      b0 = $urandom_range(12, 0); b1 = $urandom_range(10, 0); b2 = $urandom_range(10, 0);
      e[0] = (b0 == 0) ? $urandom_range(1) : (32'd1 << (b0 - 1)) + $urandom_range((1 << (b0 - 1)) - 1) + 1;
      e[1] = (b1 == 0) ? 1 : (32'd1 << (b1 - 1)) + 1;
      e[2] = (b2 == 0) ? 1 : (32'd1 << b2);
      if (ph == 11) e[0] = 32'hFFFF_FFFF;
      tot = extent_bits(e[0]) + (rk > 1 ? extent_bits(e[1]) : 0) +
            (rk > 2 ? extent_bits(e[2]) : 0);
      for (int i = 0; i < 3; i++)
        s[i] = ($urandom_range(9) == 0) ? $urandom() : (32'd1 << $urandom_range(20));
      if (ph == 3) s[1] = 0;
      if (ph == 11) s[0] = 32'hFFFF_FFFF;
      if (tot < 1 || tot > 32 || $urandom_range(9) == 0) tot = $urandom_range(63);
      set_layout(rk[1:0], s[0], s[1], s[2], e[0], e[1], e[2], tot[5:0]);
      fill_masks();
      if (ph == 5) begin
        fork
          begin
            long_hold = 1'b1;
            hold = 0;
            while (hold < 600) begin @(negedge clk); hold++; end
            long_hold = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 52; n++) begin
        if ($urandom_range(9) == 0)
          send_req(mk_write($urandom_range(31), rand64()), 1'b1, 0, '0);
        else if ($urandom_range(4) == 0)
          send_req(mk_map(rand64()), 1'b1, 0, '0);
        else
          send_req(mk_map(64'($urandom_range(1 << 20)) * s[$urandom_range(2)] +
                          $urandom_range(255)), 1'b1, 0, '0);
      end
      drain();
    end

    $display("Covered %0d maps and %0d mask writes over the reset layout and 17 others,",
             maps_sent, writes_sent);
    $display("with one long receiver hold-off; %0d responses checked.", checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d maps outstanding.", pending_maps.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
